/* rtl/lwpd_pkg.sv */
// ----------------------------------------------------------------------------
// lwpd_pkg
// Shared types and codes for the LRU write-back page directory.
// ----------------------------------------------------------------------------
package lwpd_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY    = 1'd1;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_PROMO,
        S_OUT,
        S_FI,
        S_FIW,
        S_FJ,
        S_FW,
        S_FORD,
        S_FPG,
        S_FCHK
    } t_state;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

/* rtl/lwpd_req_if.sv */
// ----------------------------------------------------------------------------
// lwpd_req_if
// Request channel: action and page number.
// ----------------------------------------------------------------------------
interface lwpd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] page_number;

    modport source (output valid, output action, output page_number, input ready);
    modport sink   (input valid, input action, input page_number, output ready);
endinterface

/* rtl/lwpd_rsp_if.sv */
// ----------------------------------------------------------------------------
// lwpd_rsp_if
// Response channel: lookup result and write-back request.
// ----------------------------------------------------------------------------
interface lwpd_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  slot;
    logic        fetch_needed;
    logic        writeback_valid;
    logic [31:0] writeback_page;
    logic [3:0]  writeback_slot;
    logic        refused;
    logic        last;

    modport source (output valid, output hit, output slot, output fetch_needed,
                    output writeback_valid, output writeback_page,
                    output writeback_slot, output refused, output last,
                    input ready);
    modport sink   (input valid, input hit, input slot, input fetch_needed,
                    input writeback_valid, input writeback_page,
                    input writeback_slot, input refused, input last,
                    output ready);
endinterface

/* rtl/lru_writeback_page_directory.sv */
// ----------------------------------------------------------------------------
// lru_writeback_page_directory
// Fully associative LRU page directory with write-back and flush.
// ----------------------------------------------------------------------------
// One item at a time, all work done by a sequencer around one 32-bit
// comparator and single-port-read memories for page, rank and flush order.
// An access runs a lookup scan, then a recency update scan over the filled
// slots. A flush first ranks the pages by page number, one compare per
// cycle, then walks the filled slots in that order and emits a write-back
// for each dirty one. Refused and ACT_NONE requests go straight to the response.
// Ready only in idle.
module lru_writeback_page_directory #(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lwpd_req_if.sink                          i_req,
    lwpd_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [lwpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lwpd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int unsigned SW = $clog2(NUM_SLOTS);
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam int unsigned ACT_RST = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;

    function automatic logic [CW-1:0] f_clamp(input logic [lwpd_pkg::CFG_DATA_W-1:0] v);
        if (v == '0) return CW'(1);
        if (32'(v) > NUM_SLOTS) return CW'(NUM_SLOTS);
        return CW'(v);
    endfunction

    lwpd_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_idx, n_idx, r_jdx, n_jdx;
    logic                 r_pend, n_pend;
    logic [SW-1:0]        r_pidx, n_pidx;
    logic [1:0]           r_action, n_action;
    logic [31:0]          r_opnd, n_opnd;
    logic                 r_hit, n_hit;
    logic [SW-1:0]        r_hslot, n_hslot, r_hrank, n_hrank;
    logic [SW-1:0]        r_vslot, n_vslot;
    logic [31:0]          r_vpage, n_vpage;
    logic [SW-1:0]        r_s, n_s, r_old, n_old;
    logic [CW-1:0]        r_filled, n_filled;
    logic [CW-1:0]        r_active;
    logic                 r_ro;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    logic [SW-1:0]        r_cnt, n_cnt, r_lrank, n_lrank, r_oidx, n_oidx;
    logic                 r_anyd, n_anyd, r_fl, n_fl;

    logic                 r_o_hit, n_o_hit, r_o_fetch, n_o_fetch;
    logic                 r_o_wbv, n_o_wbv, r_o_ref, n_o_ref, r_o_last, n_o_last;
    logic [3:0]           r_o_slot, n_o_slot, r_o_wbslot, n_o_wbslot;
    logic [31:0]          r_o_wbpage, n_o_wbpage;

    logic [31:0]          page_mem [NUM_SLOTS];
    logic [SW-1:0]        rank_mem [NUM_SLOTS];
    logic [SW-1:0]        ord_mem  [NUM_SLOTS];
    logic [31:0]          r_page_rd;
    logic [SW-1:0]        r_rank_rd, r_ord_rd;

    logic                 pg_we, rk_we, od_we;
    logic [SW-1:0]        pg_raddr, pg_waddr, rk_raddr, rk_waddr, rk_wdata;
    logic [SW-1:0]        od_raddr, od_waddr, od_wdata;
    logic [31:0]          pg_wdata;

    lwpd_pkg::t_cmp       cmp;
    logic                 req_acc, rsp_acc, scan_done, jscan_done, is_victim;

    lwpd_cmp u_cmp (.i_a(r_page_rd), .i_b(r_opnd), .o_res(cmp));

    assign req_acc    = i_req.valid && i_req.ready;
    assign rsp_acc    = o_rsp.valid && o_rsp.ready;
    assign scan_done  = (r_idx >= r_filled) && !r_pend;
    assign jscan_done = (r_jdx >= r_filled) && !r_pend;
    assign is_victim  = (CW'(r_rank_rd) == (r_filled - CW'(1)));

    assign i_req.ready          = (r_state == lwpd_pkg::S_IDLE);
    assign o_rsp.valid          = (r_state == lwpd_pkg::S_OUT);
    assign o_rsp.hit            = r_o_hit;
    assign o_rsp.slot           = r_o_slot;
    assign o_rsp.fetch_needed   = r_o_fetch;
    assign o_rsp.writeback_valid = r_o_wbv;
    assign o_rsp.writeback_page = r_o_wbpage;
    assign o_rsp.writeback_slot = r_o_wbslot;
    assign o_rsp.refused        = r_o_ref;
    assign o_rsp.last           = r_o_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lwpd_pkg::S_IDLE: begin
                if (req_acc) begin
                    if (i_req.action == lwpd_pkg::ACT_NONE) n_state = lwpd_pkg::S_OUT;
                    else if (i_req.action == lwpd_pkg::ACT_READ) n_state = lwpd_pkg::S_SCAN;
                    else if (r_ro) n_state = lwpd_pkg::S_OUT;
                    else if (i_req.action == lwpd_pkg::ACT_WRITE) n_state = lwpd_pkg::S_SCAN;
                    else n_state = lwpd_pkg::S_FI;
                end
            end
            lwpd_pkg::S_SCAN:   if (scan_done) n_state = lwpd_pkg::S_DECIDE;
            lwpd_pkg::S_DECIDE: n_state = lwpd_pkg::S_PROMO;
            lwpd_pkg::S_PROMO:  if (scan_done) n_state = lwpd_pkg::S_OUT;
            lwpd_pkg::S_OUT: begin
                if (rsp_acc) n_state = r_fl ? lwpd_pkg::S_FORD : lwpd_pkg::S_IDLE;
            end
            lwpd_pkg::S_FI: n_state = (r_idx >= r_filled) ? lwpd_pkg::S_FORD : lwpd_pkg::S_FIW;
            lwpd_pkg::S_FIW: n_state = lwpd_pkg::S_FJ;
            lwpd_pkg::S_FJ:  if (jscan_done) n_state = lwpd_pkg::S_FW;
            lwpd_pkg::S_FW:  n_state = lwpd_pkg::S_FI;
            lwpd_pkg::S_FORD: begin
                if (r_idx >= r_filled) n_state = r_anyd ? lwpd_pkg::S_IDLE : lwpd_pkg::S_OUT;
                else n_state = lwpd_pkg::S_FPG;
            end
            lwpd_pkg::S_FPG:  n_state = lwpd_pkg::S_FCHK;
            lwpd_pkg::S_FCHK: n_state = r_dirty[r_oidx] ? lwpd_pkg::S_OUT : lwpd_pkg::S_FORD;
            default: n_state = lwpd_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_idx = r_idx;  n_jdx = r_jdx;  n_pend = r_pend;  n_pidx = r_pidx;
        n_action = r_action;  n_opnd = r_opnd;  n_hit = r_hit;
        n_hslot = r_hslot;  n_hrank = r_hrank;  n_vslot = r_vslot;  n_vpage = r_vpage;
        n_s = r_s;  n_old = r_old;  n_filled = r_filled;  n_dirty = r_dirty;
        n_cnt = r_cnt;  n_lrank = r_lrank;  n_oidx = r_oidx;  n_anyd = r_anyd;
        n_fl = r_fl;
        n_o_hit = r_o_hit;  n_o_slot = r_o_slot;  n_o_fetch = r_o_fetch;
        n_o_wbv = r_o_wbv;  n_o_wbpage = r_o_wbpage;  n_o_wbslot = r_o_wbslot;
        n_o_ref = r_o_ref;  n_o_last = r_o_last;
        pg_we = 1'b0;  pg_waddr = r_s;  pg_wdata = r_opnd;  pg_raddr = r_idx[SW-1:0];
        rk_we = 1'b0;  rk_waddr = r_pidx;  rk_wdata = '0;  rk_raddr = r_idx[SW-1:0];
        od_we = 1'b0;  od_waddr = r_cnt;  od_wdata = r_idx[SW-1:0];
        od_raddr = r_idx[SW-1:0];
        case (r_state)
            lwpd_pkg::S_IDLE: begin
                n_o_hit = 1'b0;  n_o_slot = '0;  n_o_fetch = 1'b0;  n_o_wbv = 1'b0;
                n_o_wbpage = '0;  n_o_wbslot = '0;  n_o_last = 1'b1;
                n_o_ref = (i_req.action == lwpd_pkg::ACT_WRITE
                        || i_req.action == lwpd_pkg::ACT_FLUSH) && r_ro;
                n_action = i_req.action;
                n_opnd = i_req.page_number;
                n_idx = '0;  n_pend = 1'b0;  n_hit = 1'b0;  n_fl = 1'b0;
                n_anyd = 1'b0;  n_lrank = '0;
            end
            lwpd_pkg::S_SCAN: begin
                n_pend = (r_idx < r_filled);
                n_pidx = r_idx[SW-1:0];
                if (r_idx < r_filled) n_idx = r_idx + CW'(1);
                if (r_pend) begin
                    if (cmp.eq) begin
                        n_hit = 1'b1;  n_hslot = r_pidx;  n_hrank = r_rank_rd;
                    end
                    if (is_victim) begin
                        n_vslot = r_pidx;  n_vpage = r_page_rd;
                    end
                end
            end
            lwpd_pkg::S_DECIDE: begin
                n_o_hit = r_hit;  n_o_fetch = !r_hit;  n_o_last = 1'b1;
                n_o_ref = 1'b0;  n_o_wbv = 1'b0;  n_o_wbpage = '0;  n_o_wbslot = '0;
                if (r_hit) begin
                    n_s = r_hslot;  n_old = r_hrank;
                    if (r_action == lwpd_pkg::ACT_WRITE) n_dirty[r_hslot] = 1'b1;
                end else if (r_filled < r_active) begin
                    n_s = r_filled[SW-1:0];  n_old = r_filled[SW-1:0];
                    n_filled = r_filled + CW'(1);
                    pg_we = 1'b1;  pg_waddr = r_filled[SW-1:0];
                    n_dirty[r_filled[SW-1:0]] = (r_action == lwpd_pkg::ACT_WRITE);
                end else begin
                    n_s = r_vslot;  n_old = SW'(r_filled - CW'(1));
                    if (r_dirty[r_vslot]) begin
                        n_o_wbv = 1'b1;  n_o_wbpage = r_vpage;  n_o_wbslot = 4'(r_vslot);
                    end
                    pg_we = 1'b1;  pg_waddr = r_vslot;
                    n_dirty[r_vslot] = (r_action == lwpd_pkg::ACT_WRITE);
                end
                n_o_slot = 4'(n_s);
                n_idx = '0;  n_pend = 1'b0;
            end
            lwpd_pkg::S_PROMO: begin
                n_pend = (r_idx < r_filled);
                n_pidx = r_idx[SW-1:0];
                if (r_idx < r_filled) n_idx = r_idx + CW'(1);
                if (r_pend && r_pidx != r_s && r_rank_rd < r_old) begin
                    rk_we = 1'b1;  rk_waddr = r_pidx;  rk_wdata = r_rank_rd + SW'(1);
                end
                if (scan_done) begin
                    rk_we = 1'b1;  rk_waddr = r_s;  rk_wdata = '0;
                end
            end
            lwpd_pkg::S_OUT: begin
                if (rsp_acc && r_fl) n_idx = r_idx + CW'(1);
            end
            lwpd_pkg::S_FI: begin
                if (r_idx >= r_filled) n_idx = '0;
            end
            lwpd_pkg::S_FIW: begin
                n_opnd = r_page_rd;  n_jdx = '0;  n_pend = 1'b0;  n_cnt = '0;
            end
            lwpd_pkg::S_FJ: begin
                pg_raddr = r_jdx[SW-1:0];
                n_pend = (r_jdx < r_filled);
                if (r_jdx < r_filled) n_jdx = r_jdx + CW'(1);
                if (r_pend && cmp.lt) n_cnt = r_cnt + SW'(1);
            end
            lwpd_pkg::S_FW: begin
                rk_we = 1'b1;  rk_waddr = r_idx[SW-1:0];  rk_wdata = r_cnt;
                od_we = 1'b1;
                if (r_dirty[r_idx[SW-1:0]]) begin
                    n_anyd = 1'b1;
                    if (r_cnt >= r_lrank) n_lrank = r_cnt;
                end
                n_idx = r_idx + CW'(1);
            end
            lwpd_pkg::S_FORD: begin
                if (r_idx >= r_filled && !r_anyd) begin
                    n_o_hit = 1'b0;  n_o_slot = '0;  n_o_fetch = 1'b0;  n_o_wbv = 1'b0;
                    n_o_wbpage = '0;  n_o_wbslot = '0;  n_o_ref = 1'b0;
                    n_o_last = 1'b1;  n_fl = 1'b0;
                end
            end
            lwpd_pkg::S_FPG: begin
                pg_raddr = r_ord_rd;
                n_oidx = r_ord_rd;
            end
            lwpd_pkg::S_FCHK: begin
                if (r_dirty[r_oidx]) begin
                    n_o_hit = 1'b0;  n_o_slot = '0;  n_o_fetch = 1'b0;  n_o_ref = 1'b0;
                    n_o_wbv = 1'b1;  n_o_wbpage = r_page_rd;  n_o_wbslot = 4'(r_oidx);
                    n_o_last = (r_idx == CW'(r_lrank));
                    n_dirty[r_oidx] = 1'b0;
                    n_fl = 1'b1;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lwpd_pkg::S_IDLE;
            r_filled <= '0;
            r_active <= CW'(ACT_RST);
            r_ro     <= 1'b0;
            r_dirty  <= '0;
            r_pend   <= 1'b0;
            r_fl     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_filled <= n_filled;
            r_dirty  <= n_dirty;
            r_pend   <= n_pend;
            r_fl     <= n_fl;
            if (i_cfg_we) begin
                if (i_cfg_idx == lwpd_pkg::REG_ACTIVE_SLOTS && r_filled == '0)
                    r_active <= f_clamp(i_cfg_data);
                else if (i_cfg_idx == lwpd_pkg::REG_READ_ONLY)
                    r_ro <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;  r_jdx <= n_jdx;  r_pidx <= n_pidx;  r_action <= n_action;
        r_opnd <= n_opnd;  r_hit <= n_hit;  r_hslot <= n_hslot;  r_hrank <= n_hrank;
        r_vslot <= n_vslot;  r_vpage <= n_vpage;  r_s <= n_s;  r_old <= n_old;
        r_cnt <= n_cnt;  r_lrank <= n_lrank;  r_oidx <= n_oidx;  r_anyd <= n_anyd;
        r_o_hit <= n_o_hit;  r_o_slot <= n_o_slot;  r_o_fetch <= n_o_fetch;
        r_o_wbv <= n_o_wbv;  r_o_wbpage <= n_o_wbpage;  r_o_wbslot <= n_o_wbslot;
        r_o_ref <= n_o_ref;  r_o_last <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) page_mem[pg_waddr] <= pg_wdata;
        r_page_rd <= page_mem[pg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rk_we) rank_mem[rk_waddr] <= rk_wdata;
        r_rank_rd <= rank_mem[rk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (od_we) ord_mem[od_waddr] <= od_wdata;
        r_ord_rd <= ord_mem[od_raddr];
    end

    a_filled_le_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= r_active)
        else $error("filled slot count exceeds active slots");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state != lwpd_pkg::S_IDLE))
        else $error("request transaction did not start work");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_acc && o_rsp.last) |=> !o_rsp.valid)
        else $error("response valid right after final transaction");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.refused) |-> (!o_rsp.writeback_valid && !o_rsp.hit))
        else $error("refused response carries lookup data");
endmodule

/* rtl/lwpd_cmp.sv */
// ----------------------------------------------------------------------------
// lwpd_cmp
// Shared page number comparator used by lookup and flush ordering.
// ----------------------------------------------------------------------------
module lwpd_cmp (
    input  logic [31:0]    i_a,
    input  logic [31:0]    i_b,
    output lwpd_pkg::t_cmp o_res
);
    assign o_res.eq = (i_a == i_b);
    assign o_res.lt = (i_a < i_b);
endmodule

/* tb/tb_lru_writeback_page_directory.sv */
// ----------------------------------------------------------------------------
// tb_lru_writeback_page_directory
// Self-checking bench for the LRU write-back page directory: a queue-fed
// driver, a monitor comparing each response transaction with a predicted
// directory, random gaps on both channels, one slot count and read-only on/off.
// ----------------------------------------------------------------------------
module tb_lru_writeback_page_directory;

    localparam int unsigned NSLOT = 16;
    localparam int unsigned CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] page;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        fetch_needed;
        logic        wb_valid;
        logic [31:0] wb_page;
        logic [3:0]  wb_slot;
        logic        refused;
        logic        last;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lwpd_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [lwpd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    lwpd_req_if req_ch();
    lwpd_rsp_if rsp_ch();

    lru_writeback_page_directory #(.NUM_SLOTS(NSLOT)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // directory shadow
    logic [31:0] dir_page [NSLOT];
    logic        dir_dirty [NSLOT];
    int unsigned dir_rank [NSLOT];
    int unsigned dir_filled;
    int unsigned dir_active;
    logic        dir_ro;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_wb = 0;
    int unsigned gap_req = 0;
    int unsigned gap_rsp = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = '0;
        req_ch.page_number = '0;
        rsp_ch.ready = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void make_recent(int unsigned s, int unsigned old_rank);
        for (int unsigned i = 0; i < dir_filled; i++)
            if (i != s && dir_rank[i] < old_rank) dir_rank[i]++;
        dir_rank[s] = 0;
    endfunction

    function automatic void predict_lookup(t_req r);
        t_rsp o;
        int unsigned s;
        logic found;
        o = '0;
        s = 0;
        found = 1'b0;
        o.last = 1'b1;
        if (r.action == lwpd_pkg::ACT_NONE) begin
            expected_rsps.push_back(o);
            return;
        end
        if (dir_ro && r.action != lwpd_pkg::ACT_READ) begin
            o.refused = 1'b1;
            expected_rsps.push_back(o);
            return;
        end
        if (r.action == lwpd_pkg::ACT_FLUSH) begin
            int unsigned cnt;
            int k;
            for (int unsigned i = 0; i < dir_filled; i++) begin
                cnt = 0;
                for (int unsigned j = 0; j < dir_filled; j++)
                    if (dir_page[j] < dir_page[i]) cnt++;
                dir_rank[i] = cnt;
            end
            k = 0;
            for (int unsigned rk = 0; rk < dir_filled; rk++)
                for (int unsigned i = 0; i < dir_filled; i++)
                    if (dir_rank[i] == rk && dir_dirty[i]) begin
                        o = '0;
                        o.wb_valid = 1'b1;
                        o.wb_page = dir_page[i];
                        o.wb_slot = i[3:0];
                        dir_dirty[i] = 1'b0;
                        expected_rsps.push_back(o);
                        k++;
                    end
            if (k == 0) begin
                o = '0;
                o.last = 1'b1;
                expected_rsps.push_back(o);
            end else begin
                expected_rsps[$].last = 1'b1;
            end
            return;
        end
        for (int unsigned i = 0; i < dir_filled; i++)
            if (!found && dir_page[i] == r.page) begin
                s = i;
                found = 1'b1;
            end
        if (found) begin
            make_recent(s, dir_rank[s]);
        end else if (dir_filled < dir_active) begin
            s = dir_filled;
            dir_filled++;
            dir_page[s] = r.page;
            dir_dirty[s] = 1'b0;
            make_recent(s, dir_filled - 1);
        end else begin
            for (int unsigned i = 0; i < dir_filled; i++)
                if (dir_rank[i] == dir_filled - 1) s = i;
            if (dir_dirty[s]) begin
                o.wb_valid = 1'b1;
                o.wb_page = dir_page[s];
                o.wb_slot = s[3:0];
            end
            dir_page[s] = r.page;
            dir_dirty[s] = 1'b0;
            make_recent(s, dir_rank[s]);
        end
        if (r.action == lwpd_pkg::ACT_WRITE) dir_dirty[s] = 1'b1;
        o.hit = found;
        o.slot = s[3:0];
        o.fetch_needed = !found;
        expected_rsps.push_back(o);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (req_ch.valid && req_ch.ready) begin
            predict_lookup('{action: req_ch.action, page: req_ch.page_number});
            n_sent++;
        end
        if (req_ch.valid && !req_ch.ready) begin
            // hold
        end else if (gap_req != 0) begin
            gap_req--;
            req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && i_rst_n) begin
            t_req r;
            r = pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.action <= r.action;
            req_ch.page_number <= r.page;
            gap_req = pick_gap();
        end else begin
            req_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        if (rsp_ch.valid && rsp_ch.ready) begin
            t_rsp a, e;
            a = '{rsp_ch.hit, rsp_ch.slot, rsp_ch.fetch_needed, rsp_ch.writeback_valid,
                  rsp_ch.writeback_page, rsp_ch.writeback_slot, rsp_ch.refused,
                  rsp_ch.last};
            if (expected_rsps.size() == 0) begin
                $error("unexpected response transaction");
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                n_checked++;
                if (a.wb_valid) n_wb++;
                if (a.hit != e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
                end
                if (a.slot != e.slot) begin
                    $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
                end
                if (a.fetch_needed != e.fetch_needed) begin
                    $error("fetch_needed exp %0d got %0d", e.fetch_needed,
                           a.fetch_needed); errors++;
                end
                if (a.wb_valid != e.wb_valid) begin
                    $error("writeback_valid exp %0d got %0d", e.wb_valid,
                           a.wb_valid); errors++;
                end
                if (a.wb_page != e.wb_page) begin
                    $error("writeback_page exp %h got %h", e.wb_page, a.wb_page);
                    errors++;
                end
                if (a.wb_slot != e.wb_slot) begin
                    $error("writeback_slot exp %0d got %0d", e.wb_slot, a.wb_slot);
                    errors++;
                end
                if (a.refused != e.refused) begin
                    $error("refused exp %0d got %0d", e.refused, a.refused); errors++;
                end
                if (a.last != e.last) begin
                    $error("last exp %0d got %0d", e.last, a.last); errors++;
                end
            end
        end
        if (gap_rsp != 0) begin
            gap_rsp--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            gap_rsp = pick_gap();
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lwpd_pkg::CFG_IDX_W-1:0] idx,
                             logic [lwpd_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lwpd_pkg::REG_ACTIVE_SLOTS) begin
            if (dir_filled == 0)
                dir_active = (val == 0) ? 1 : (val > NSLOT ? NSLOT : val);
        end else begin
            dir_ro = val[0];
        end
    endtask

    function automatic void add_req(logic [1:0] act, logic [31:0] pg);
        pending_reqs.push_back('{action: act, page: pg});
    endfunction

    // small page pool keeps hits frequent; a few wide values hit every bit
    function automatic logic [31:0] rand_page(int unsigned pool);
        if ($urandom_range(0, 9) == 0) return $urandom();
        return 32'hFFFF_FFF0 ^ $urandom_range(0, pool);
    endfunction

    task automatic random_phase(int unsigned n, int unsigned pool);
        int unsigned r;
        logic [1:0] act;
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            act = (r < 50) ? lwpd_pkg::ACT_READ : (r < 88) ? lwpd_pkg::ACT_WRITE :
                  (r < 96) ? lwpd_pkg::ACT_FLUSH : lwpd_pkg::ACT_NONE;
            add_req(act, rand_page(pool));
        end
    endtask

    initial begin
        dir_filled = 0;
        dir_active = NSLOT;
        dir_ro = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            dir_dirty[i] = 1'b0;
            dir_page[i] = '0;
            dir_rank[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: extremes, each action, refusal, empty flush, eviction
        write_reg(lwpd_pkg::REG_ACTIVE_SLOTS, 5'd2);
        add_req(lwpd_pkg::ACT_FLUSH, 32'h0);
        add_req(lwpd_pkg::ACT_READ, 32'h0);
        add_req(lwpd_pkg::ACT_WRITE, 32'hFFFF_FFFF);
        add_req(lwpd_pkg::ACT_WRITE, 32'h0);
        add_req(lwpd_pkg::ACT_READ, 32'h1234_5678);
        add_req(lwpd_pkg::ACT_WRITE, 32'hFFFF_FFFF);
        add_req(lwpd_pkg::ACT_WRITE, 32'h8000_0000);
        add_req(lwpd_pkg::ACT_NONE, 32'hFFFF_FFFF);
        add_req(lwpd_pkg::ACT_FLUSH, 32'hFFFF_FFFF);
        add_req(lwpd_pkg::ACT_FLUSH, 32'h0);
        wait_drained();
        write_reg(lwpd_pkg::REG_ACTIVE_SLOTS, 5'd9);  // ignored, cache not empty
        write_reg(lwpd_pkg::REG_READ_ONLY, 1'b1);
        add_req(lwpd_pkg::ACT_WRITE, 32'h5);
        add_req(lwpd_pkg::ACT_FLUSH, 32'h0);
        add_req(lwpd_pkg::ACT_READ, 32'h5);
        add_req(lwpd_pkg::ACT_NONE, 32'h0);
        wait_drained();
        write_reg(lwpd_pkg::REG_READ_ONLY, 1'b0);

        random_phase(80, 5);
        wait_drained();
        random_phase(80, 24);
        wait_drained();
        write_reg(lwpd_pkg::REG_READ_ONLY, 1'b1);
        random_phase(30, 8);
        wait_drained();
        write_reg(lwpd_pkg::REG_READ_ONLY, 1'b0);
        random_phase(110, 20);
        wait_drained();

        $display("Checked %0d response transactions (%0d write-backs) from %0d requests.",
                 n_checked, n_wb, n_sent);
        $display("Settings: slot count 2, read-only on/off, page pools of 5..24.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/lwpd_pkg.sv
rtl/lwpd_req_if.sv
rtl/lwpd_rsp_if.sv
rtl/lwpd_cmp.sv
rtl/lru_writeback_page_directory.sv
tb/tb_lru_writeback_page_directory.sv
